[hdl/rsi_pkg.sv]
// Shared widths, register indexes and pipeline context types for the ray-sphere unit.
`default_nettype none
package rsi_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = 3;

	localparam logic [IDX_W-1:0] REG_CENTER_X = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_CENTER_Y = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CENTER_Z = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_RADIUS   = IDX_W'(3);

	localparam int RW     = COORD_BITS - 1;          // radius
	localparam int C_W    = COORD_BITS + 1;          // center minus origin
	localparam int C2_W   = 2 * COORD_BITS + 2;      // |c|^2
	localparam int D2_W   = 2 * COORD_BITS;          // |d|^2
	localparam int LEN_W  = COORD_BITS + FRAC_BITS;  // |d| scaled
	localparam int UM_W   = FRAC_BITS + 1;           // unit component magnitude
	localparam int U_W    = FRAC_BITS + 2;           // signed unit component
	localparam int CU_W   = C_W + U_W;
	localparam int DOT_W  = CU_W + 2;
	localparam int PROJ_W = COORD_BITS + 2;
	localparam int P2_W   = 2 * PROJ_W;
	localparam int R2_W   = 2 * RW;
	localparam int T_W    = PROJ_W + 2;
	localparam int UT_W   = U_W + T_W;
	localparam int V_W    = UT_W - FRAC_BITS;
	localparam int PT_W   = V_W + 1;
	localparam int DV_W   = V_W + 1;
	localparam int NUM_W  = DV_W + FRAC_BITS;
	localparam int OV_W   = NUM_W + COORD_BITS;

	typedef struct packed {
		logic                         valid;
		logic [2:0][COORD_BITS-1:0]   org;
		logic [2:0][C_W-1:0]          c;
		logic [2:0][COORD_BITS-1:0]   dmag;
		logic [2:0]                   dneg;
		logic [C2_W-1:0]              c2;
		logic                         zero_dir;
	} ray_ctx_t;

	typedef struct packed {
		logic                         valid;
		logic                         miss;
		logic                         in_sph;
		logic [2:0][COORD_BITS-1:0]   org;
		logic [2:0][C_W-1:0]          c;
		logic [2:0][U_W-1:0]          u;
		logic [PROJ_W-1:0]            proj;
	} hit_ctx_t;

	typedef struct packed {
		logic                         valid;
		logic                         miss;
		logic                         in_sph;
		logic                         rzero;
		logic [2:0][COORD_BITS-1:0]   point;
		logic [2:0]                   neg;
		logic [2:0]                   ovf;
	} nrm_ctx_t;

endpackage
`default_nettype wire

[hdl/rsi_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rsi_sqrt_pipe #(
	parameter int OUT_W = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2*OUT_W-1:0]   radicand,
	output logic [OUT_W-1:0]     root
);

	localparam int IN_W = 2 * OUT_W;
	localparam int IW   = IN_W + 2;

	logic [IN_W-1:0]  rem_s  [1:OUT_W];
	logic [OUT_W-1:0] root_s [1:OUT_W];

	for (genvar k = 0; k < OUT_W; k++) begin : g_stage
		logic [IN_W-1:0]  rem_in;
		logic [OUT_W-1:0] root_in;
		logic [IW-1:0]    term;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_in  = radicand;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
		assign term = (IW'(root_in) << (OUT_W - k)) + (IW'(1) << (2 * (OUT_W - 1 - k)));
		assign take = IW'(rem_in) >= term;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? IN_W'(IW'(rem_in) - term) : rem_in;
				root_s[k+1] <= take ? (root_in | (OUT_W'(1) << (OUT_W - 1 - k))) : root_in;
			end
		end
	end

	assign root = root_s[OUT_W];

endmodule
`default_nettype wire

[hdl/rsi_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rsi_div_pipe #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8,
	parameter int Q_W   = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	localparam int IW = NUM_W + DEN_W + Q_W;

	logic [NUM_W-1:0] rem_s [1:Q_W];
	logic [DEN_W-1:0] den_s [1:Q_W];
	logic [Q_W-1:0]   quo_s [1:Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [IW-1:0]    trial;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign quo_in = quo_s[k];
		end

		assign trial = IW'(den_in) << (Q_W - 1 - k);
		assign take  = IW'(rem_in) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? NUM_W'(IW'(rem_in) - trial) : rem_in;
				den_s[k+1] <= den_in;
				quo_s[k+1] <= take ? (quo_in | (Q_W'(1) << (Q_W - 1 - k))) : quo_in;
			end
		end
	end

	assign quo = quo_s[Q_W];

endmodule
`default_nettype wire

[hdl/rsi_delay.sv]
// Delay line that carries context words alongside the arithmetic units.
`default_nettype none
module rsi_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_s [1:DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DEPTH; i++) tap_s[i] <= '0;
		end else if (en) begin
			tap_s[1] <= din;
			for (int i = 2; i <= DEPTH; i++) tap_s[i] <= tap_s[i-1];
		end
	end

	assign dout = tap_s[DEPTH];

endmodule
`default_nettype wire

[hdl/ray_sphere_intersection.sv]
// Ray-sphere intersection engine, geometric method, signed Q16.16.
//
// Each accepted ray word (origin, direction) yields exactly one result word:
// hit, from_inside, the intersection point and the unit normal. The direction
// is normalized in hardware, so any nonzero length works; a zero direction is
// a miss. The sphere center and radius come from the write port (index 0..2:
// center x/y/z, index 3: radius, other indexes ignored) and must only be
// written while no ray is in flight. The datapath is a fully pipelined chain:
// one ray enters per clock unless the result side stalls. The chain is built
// from the bit-per-stage units: the square root for |d| (48 stages), the
// three unit-vector dividers (17), the square root for the half chord (31)
// and the three normal dividers (32), plus 13 stages of multiply/add/compare.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on the result side holds every stage in place
// and loses or repeats nothing. Points and normals saturate to the signed
// 32-bit range; a miss returns all zeros.
`default_nettype none
module ray_sphere_intersection
	import rsi_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_index,
	input  logic [COORD_BITS-1:0] wr_data,
	input  logic                  ray_valid,
	output logic                  ray_ready,
	input  logic [COORD_BITS-1:0] origin_x,
	input  logic [COORD_BITS-1:0] origin_y,
	input  logic [COORD_BITS-1:0] origin_z,
	input  logic [COORD_BITS-1:0] dir_x,
	input  logic [COORD_BITS-1:0] dir_y,
	input  logic [COORD_BITS-1:0] dir_z,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  hit,
	output logic                  from_inside,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic [COORD_BITS-1:0] point_z,
	output logic [COORD_BITS-1:0] normal_x,
	output logic [COORD_BITS-1:0] normal_y,
	output logic [COORD_BITS-1:0] normal_z
);

	localparam int W = COORD_BITS;
	localparam int F = FRAC_BITS;

	// configuration registers
	logic [W-1:0]  center_x_q, center_y_q, center_z_q;
	logic [RW-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RW'(1) << F;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X: center_x_q <= wr_data;
				REG_CENTER_Y: center_y_q <= wr_data;
				REG_CENTER_Z: center_z_q <= wr_data;
				REG_RADIUS:   radius_q   <= wr_data[RW-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipeline unless a finished word is stuck at the output
	logic en;
	assign en        = !res_valid || res_ready;
	assign ray_ready = en;

	logic [2:0][W-1:0] org_in, dir_in, cen;
	assign org_in = {origin_z, origin_y, origin_x};
	assign dir_in = {dir_z, dir_y, dir_x};
	assign cen    = {center_z_q, center_y_q, center_x_q};

	// ---- stage 1: c = center - origin, |d_i| and signs
	logic                v_s1;
	logic [2:0][W-1:0]   org_s1, dmag_s1;
	logic [2:0][C_W-1:0] c_s1;
	logic [2:0]          dneg_s1;
	logic [2:0][C_W-1:0] c_n1;
	logic [2:0][W-1:0]   dmag_n1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_n1[i]    = C_W'($signed(cen[i])) - C_W'($signed(org_in[i]));
			dmag_n1[i] = dir_in[i][W-1] ? W'(-dir_in[i]) : dir_in[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; org_s1 <= '0; dmag_s1 <= '0; c_s1 <= '0; dneg_s1 <= '0;
		end else if (en) begin
			v_s1    <= ray_valid;
			org_s1  <= org_in;
			c_s1    <= c_n1;
			dmag_s1 <= dmag_n1;
			dneg_s1 <= {dir_in[2][W-1], dir_in[1][W-1], dir_in[0][W-1]};
		end
	end

	// ---- stage 2: squares of the components
	logic                 v_s2;
	logic [2:0][W-1:0]    org_s2, dmag_s2;
	logic [2:0][C_W-1:0]  c_s2;
	logic [2:0]           dneg_s2;
	logic [2:0][D2_W-1:0] dsq_s2;
	logic [2:0][C2_W-1:0] csq_s2;
	logic [2:0][C_W-1:0]  cmag_n2;
	logic [2:0][D2_W-1:0] dsq_n2;
	logic [2:0][C2_W-1:0] csq_n2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmag_n2[i] = c_s1[i][C_W-1] ? C_W'(-c_s1[i]) : c_s1[i];
			dsq_n2[i]  = D2_W'(dmag_s1[i]) * D2_W'(dmag_s1[i]);
			csq_n2[i]  = C2_W'(cmag_n2[i]) * C2_W'(cmag_n2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; org_s2 <= '0; dmag_s2 <= '0; c_s2 <= '0; dneg_s2 <= '0;
			dsq_s2 <= '0; csq_s2 <= '0;
		end else if (en) begin
			v_s2    <= v_s1;
			org_s2  <= org_s1;
			dmag_s2 <= dmag_s1;
			c_s2    <= c_s1;
			dneg_s2 <= dneg_s1;
			dsq_s2  <= dsq_n2;
			csq_s2  <= csq_n2;
		end
	end

	// ---- stage 3: |d|^2 and |c|^2
	ray_ctx_t        rctx_s3;
	logic [D2_W-1:0] d2_s3;
	logic [D2_W-1:0] d2_n3;

	assign d2_n3 = dsq_s2[0] + dsq_s2[1] + dsq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctx_s3 <= '0;
			d2_s3   <= '0;
		end else if (en) begin
			rctx_s3.valid    <= v_s2;
			rctx_s3.org      <= org_s2;
			rctx_s3.c        <= c_s2;
			rctx_s3.dmag     <= dmag_s2;
			rctx_s3.dneg     <= dneg_s2;
			rctx_s3.c2       <= csq_s2[0] + csq_s2[1] + csq_s2[2];
			rctx_s3.zero_dir <= d2_n3 == '0;
			d2_s3            <= d2_n3;
		end
	end

	// ---- length of d, scaled by 2^F
	logic [LEN_W-1:0] len;
	ray_ctx_t         rctx_len;

	rsi_sqrt_pipe #(.OUT_W(LEN_W)) u_len_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({d2_s3, {(2*F){1'b0}}}),
		.root     (len)
	);

	rsi_delay #(.WIDTH($bits(ray_ctx_t)), .DEPTH(LEN_W)) u_len_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (rctx_s3),
		.dout   (rctx_len)
	);

	// ---- unit vector magnitudes
	logic [2:0][UM_W-1:0] umag;
	ray_ctx_t             rctx_u;

	for (genvar g = 0; g < 3; g++) begin : g_unit
		rsi_div_pipe #(.NUM_W(W + 2*F), .DEN_W(LEN_W), .Q_W(UM_W)) u_unit_div (
			.clk (clk),
			.en  (en),
			.num ({rctx_len.dmag[g], {(2*F){1'b0}}}),
			.den (len),
			.quo (umag[g])
		);
	end

	rsi_delay #(.WIDTH($bits(ray_ctx_t)), .DEPTH(UM_W)) u_unit_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (rctx_len),
		.dout   (rctx_u)
	);

	// ---- stage 4: signed unit vector and c_i*u_i
	ray_ctx_t             rctx_s4;
	logic [2:0][U_W-1:0]  u_s4;
	logic [2:0][CU_W-1:0] cu_s4;
	logic [2:0][U_W-1:0]  u_n4;
	logic [2:0][CU_W-1:0] cu_n4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_n4[i]  = rctx_u.dneg[i] ? U_W'(-U_W'(umag[i])) : U_W'(umag[i]);
			cu_n4[i] = CU_W'($signed(rctx_u.c[i])) * CU_W'($signed(u_n4[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctx_s4 <= '0; u_s4 <= '0; cu_s4 <= '0;
		end else if (en) begin
			rctx_s4 <= rctx_u;
			u_s4    <= u_n4;
			cu_s4   <= cu_n4;
		end
	end

	// ---- stage 5: dot product c.u
	ray_ctx_t            rctx_s5;
	logic [2:0][U_W-1:0] u_s5;
	logic [DOT_W-1:0]    dot_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctx_s5 <= '0; u_s5 <= '0; dot_s5 <= '0;
		end else if (en) begin
			rctx_s5 <= rctx_s4;
			u_s5    <= u_s4;
			dot_s5  <= DOT_W'($signed(cu_s4[0])) + DOT_W'($signed(cu_s4[1]))
				+ DOT_W'($signed(cu_s4[2]));
		end
	end

	// ---- stage 6: projection, proj^2 and r^2; drop rays with zero direction or behind
	ray_ctx_t            rctx_s6;
	logic [2:0][U_W-1:0] u_s6;
	logic [PROJ_W-1:0]   proj_s6;
	logic                miss_s6;
	logic [P2_W-1:0]     p2_s6;
	logic [R2_W-1:0]     r2_s6;
	logic [PROJ_W-1:0]   proj_n6;

	assign proj_n6 = dot_s5[F +: PROJ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctx_s6 <= '0; u_s6 <= '0; proj_s6 <= '0; miss_s6 <= 1'b0;
			p2_s6 <= '0; r2_s6 <= '0;
		end else if (en) begin
			rctx_s6 <= rctx_s5;
			u_s6    <= u_s5;
			proj_s6 <= proj_n6;
			miss_s6 <= rctx_s5.zero_dir || dot_s5[DOT_W-1];
			p2_s6   <= P2_W'(proj_n6) * P2_W'(proj_n6);
			r2_s6   <= R2_W'(radius_q) * R2_W'(radius_q);
		end
	end

	// ---- stage 7: squared perpendicular distance, clamped at zero
	ray_ctx_t            rctx_s7;
	logic [2:0][U_W-1:0] u_s7;
	logic [PROJ_W-1:0]   proj_s7;
	logic                miss_s7;
	logic [R2_W-1:0]     r2_s7;
	logic [C2_W-1:0]     h2_s7;
	logic [P2_W-1:0]     c2x_n7;

	assign c2x_n7 = P2_W'(rctx_s6.c2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rctx_s7 <= '0; u_s7 <= '0; proj_s7 <= '0; miss_s7 <= 1'b0;
			r2_s7 <= '0; h2_s7 <= '0;
		end else if (en) begin
			rctx_s7 <= rctx_s6;
			u_s7    <= u_s6;
			proj_s7 <= proj_s6;
			miss_s7 <= miss_s6;
			r2_s7   <= r2_s6;
			h2_s7   <= (p2_s6 <= c2x_n7) ? C2_W'(c2x_n7 - p2_s6) : '0;
		end
	end

	// ---- stage 8: range test, inside test, r^2 - h2
	hit_ctx_t        hctx_s8;
	logic [R2_W-1:0] diff_s8;
	logic [C2_W-1:0] r2x_n8;

	assign r2x_n8 = C2_W'(r2_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hctx_s8 <= '0;
			diff_s8 <= '0;
		end else if (en) begin
			hctx_s8.valid  <= rctx_s7.valid;
			hctx_s8.miss   <= miss_s7 || (h2_s7 > r2x_n8);
			hctx_s8.in_sph <= rctx_s7.c2 <= r2x_n8;
			hctx_s8.org    <= rctx_s7.org;
			hctx_s8.c      <= rctx_s7.c;
			hctx_s8.u      <= u_s7;
			hctx_s8.proj   <= proj_s7;
			diff_s8        <= R2_W'(r2x_n8 - h2_s7);
		end
	end

	// ---- half chord length
	logic [RW-1:0] half;
	hit_ctx_t      hctx_h;

	rsi_sqrt_pipe #(.OUT_W(RW)) u_half_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (diff_s8),
		.root     (half)
	);

	rsi_delay #(.WIDTH($bits(hit_ctx_t)), .DEPTH(RW)) u_half_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (hctx_s8),
		.dout   (hctx_h)
	);

	// ---- stage 9: distance along the ray, far point when inside
	hit_ctx_t       hctx_s9;
	logic [T_W-1:0] t_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hctx_s9 <= '0;
			t_s9    <= '0;
		end else if (en) begin
			hctx_s9 <= hctx_h;
			t_s9    <= hctx_h.in_sph ? T_W'(hctx_h.proj) + T_W'(half)
				: T_W'(hctx_h.proj) - T_W'(half);
		end
	end

	// ---- stage 10: u_i * t
	hit_ctx_t             hctx_s10;
	logic [2:0][UT_W-1:0] ut_s10;
	logic [2:0][UT_W-1:0] ut_n10;

	always_comb begin
		for (int i = 0; i < 3; i++)
			ut_n10[i] = UT_W'($signed(hctx_s9.u[i])) * UT_W'($signed(t_s9));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hctx_s10 <= '0;
			ut_s10   <= '0;
		end else if (en) begin
			hctx_s10 <= hctx_s9;
			ut_s10   <= ut_n10;
		end
	end

	// ---- stage 11: point (saturated) and normal numerator
	nrm_ctx_t              nctx_s11;
	logic [2:0][NUM_W-1:0] num_s11;
	logic [2:0][V_W-1:0]   v_n11;
	logic [2:0][PT_W-1:0]  psum_n11;
	logic [2:0][DV_W-1:0]  dv_n11, dmag_n11;
	logic [2:0][W-1:0]     pt_n11;
	logic [2:0]            fits_n11;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// arithmetic shift of the product is the floor
			v_n11[i]    = ut_s10[i][UT_W-1:F];
			psum_n11[i] = PT_W'($signed(hctx_s10.org[i])) + PT_W'($signed(v_n11[i]));
			fits_n11[i] = (&psum_n11[i][PT_W-1:W-1]) || !(|psum_n11[i][PT_W-1:W-1]);
			pt_n11[i]   = fits_n11[i] ? psum_n11[i][W-1:0]
				: {psum_n11[i][PT_W-1], {(W-1){!psum_n11[i][PT_W-1]}}};
			dv_n11[i]   = DV_W'($signed(v_n11[i])) - DV_W'($signed(hctx_s10.c[i]));
			dmag_n11[i] = dv_n11[i][DV_W-1] ? DV_W'(-dv_n11[i]) : dv_n11[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nctx_s11 <= '0;
			num_s11  <= '0;
		end else if (en) begin
			nctx_s11.valid  <= hctx_s10.valid;
			nctx_s11.miss   <= hctx_s10.miss;
			nctx_s11.in_sph <= hctx_s10.in_sph;
			nctx_s11.rzero  <= radius_q == '0;
			nctx_s11.point  <= pt_n11;
			nctx_s11.ovf    <= '0;
			for (int i = 0; i < 3; i++) begin
				nctx_s11.neg[i] <= dv_n11[i][DV_W-1] ^ hctx_s10.in_sph;
				num_s11[i]      <= {dmag_n11[i][DV_W-1:0], {F{1'b0}}};
			end
		end
	end

	// ---- stage 12: flag quotients that cannot fit the divider
	nrm_ctx_t              nctx_s12;
	nrm_ctx_t              nctx_n12;
	logic [2:0][NUM_W-1:0] num_s12;
	logic [OV_W-1:0]       rlim_n12;

	assign rlim_n12 = OV_W'(radius_q) << W;

	always_comb begin
		nctx_n12 = nctx_s11;
		for (int i = 0; i < 3; i++)
			nctx_n12.ovf[i] = OV_W'(num_s11[i]) >= rlim_n12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nctx_s12 <= '0;
			num_s12  <= '0;
		end else if (en) begin
			nctx_s12 <= nctx_n12;
			num_s12  <= num_s11;
		end
	end

	// ---- normal magnitudes
	logic [2:0][W-1:0] nq;
	nrm_ctx_t          nctx_n;

	for (genvar g = 0; g < 3; g++) begin : g_norm
		rsi_div_pipe #(.NUM_W(NUM_W), .DEN_W(RW), .Q_W(W)) u_norm_div (
			.clk (clk),
			.en  (en),
			.num (num_s12[g]),
			.den (radius_q),
			.quo (nq[g])
		);
	end

	rsi_delay #(.WIDTH($bits(nrm_ctx_t)), .DEPTH(W)) u_norm_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (nctx_s12),
		.dout   (nctx_n)
	);

	// ---- output register: sign, saturate, zero on miss
	logic [2:0][W-1:0] nrm_n, pt_n;
	logic [2:0][W-1:0] point_q, normal_q;
	logic              hit_q, inside_q, res_valid_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (nctx_n.rzero) begin
				nrm_n[i] = '0;
			end else if (!nctx_n.neg[i]) begin
				nrm_n[i] = (nctx_n.ovf[i] || nq[i][W-1]) ? {1'b0, {(W-1){1'b1}}} : nq[i];
			end else begin
				nrm_n[i] = (nctx_n.ovf[i] || (nq[i][W-1] && (|nq[i][W-2:0])))
					? {1'b1, {(W-1){1'b0}}} : W'(-nq[i]);
			end
			if (nctx_n.miss) nrm_n[i] = '0;
			pt_n[i] = nctx_n.miss ? '0 : nctx_n.point[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			inside_q    <= 1'b0;
			point_q     <= '0;
			normal_q    <= '0;
		end else if (en) begin
			res_valid_q <= nctx_n.valid;
			hit_q       <= !nctx_n.miss;
			inside_q    <= !nctx_n.miss && nctx_n.in_sph;
			point_q     <= pt_n;
			normal_q    <= nrm_n;
		end
	end

	assign res_valid   = res_valid_q;
	assign hit         = hit_q;
	assign from_inside = inside_q;
	assign point_x     = point_q[0];
	assign point_y     = point_q[1];
	assign point_z     = point_q[2];
	assign normal_x    = normal_q[0];
	assign normal_y    = normal_q[1];
	assign normal_z    = normal_q[2];

endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the ray-sphere intersection engine.
`default_nettype none
module testbench
	import rsi_pkg::*;
;

	typedef struct packed {
		logic                       hit;
		logic                       in_sph;
		logic [2:0][COORD_BITS-1:0] point;
		logic [2:0][COORD_BITS-1:0] normal;
	} isect_t;

	localparam longint ONE      = 64'sd65536;
	localparam int     HOLD_LEN = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [IDX_W-1:0]      wr_index = '0;
	logic [COORD_BITS-1:0] wr_data = '0;
	logic                  ray_valid = 1'b0;
	logic                  ray_ready;
	logic [COORD_BITS-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic [COORD_BITS-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	logic                  hit, from_inside;
	logic [COORD_BITS-1:0] point_x, point_y, point_z;
	logic [COORD_BITS-1:0] normal_x, normal_y, normal_z;

	// Shadow copy of the sphere registers
	longint      sph_center [3] = '{0, 0, 0};
	longint      sph_radius = ONE;

	isect_t      pending_isects [$];
	int          errors = 0;
	bit          quiet = 1'b0;      // no idling on either side
	int          hold_asks = 0;     // bumped by a test to ask for a long receiver hold

	ray_sphere_intersection i_dut (.*);

	always #10 clk = ~clk;

	function automatic logic [127:0] isqrt(logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] cc;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			cc = {64'd0, c} * {64'd0, c};
			if (cc <= n)
				r = c;
		end
		return {64'd0, r};
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp32(longint x);
		if (x > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (x < -64'sd2147483648)
			return 32'h8000_0000;
		return x[31:0];
	endfunction

	// Geometric intersection, bit exact with the engine's rounding
	function automatic isect_t trace_ray(logic [2:0][COORD_BITS-1:0] org,
			logic [2:0][COORD_BITS-1:0] dir);
		isect_t       res;
		longint       o [3];
		longint       d [3];
		longint       c [3];
		longint       u [3];
		longint       m, dot, proj, t, v, n;
		logic [127:0] w, d2, c2, len, q, p2, h2, r2, s;
		bit           in_sph;
		res = '0;
		d2 = '0;
		c2 = '0;
		for (int i = 0; i < 3; i++) begin
			o[i] = longint'($signed(org[i]));
			d[i] = longint'($signed(dir[i]));
			c[i] = sph_center[i] - o[i];
			m = d[i] < 0 ? -d[i] : d[i];
			w = 128'(m);
			d2 += w * w;
			m = c[i] < 0 ? -c[i] : c[i];
			w = 128'(m);
			c2 += w * w;
		end
		if (d2 == 0)
			return res;
		len = isqrt(d2 << (2 * FRAC_BITS));
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			m = d[i] < 0 ? -d[i] : d[i];
			q = (128'(m) << (2 * FRAC_BITS)) / len;
			u[i] = d[i] < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
			dot += c[i] * u[i];
		end
		if (dot < 0)
			return res;
		proj = dot >>> FRAC_BITS;
		p2 = 128'(proj) * 128'(proj);
		h2 = (p2 <= c2) ? c2 - p2 : '0;
		r2 = 128'(sph_radius) * 128'(sph_radius);
		if (h2 > r2)
			return res;
		s = isqrt(r2 - h2);
		in_sph = (c2 <= r2);
		t = in_sph ? proj + longint'(s[63:0]) : proj - longint'(s[63:0]);
		res.hit = 1'b1;
		res.in_sph = in_sph;
		for (int i = 0; i < 3; i++) begin
			v = (u[i] * t) >>> FRAC_BITS;
			n = 0;
			if (sph_radius != 0) begin
				n = ((v - c[i]) * ONE) / sph_radius;
				if (in_sph)
					n = -n;
			end
			res.point[i] = clamp32(o[i] + v);
			res.normal[i] = clamp32(n);
		end
		return res;
	endfunction

	// Offer one ray word, hold it until taken, then queue its expected result
	task automatic send_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			ray_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		origin_x <= ox[31:0];
		origin_y <= oy[31:0];
		origin_z <= oz[31:0];
		dir_x <= dx[31:0];
		dir_y <= dy[31:0];
		dir_z <= dz[31:0];
		ray_valid <= 1'b1;
		do @(posedge clk); while (!ray_ready);
		pending_isects.push_back(trace_ray({oz[31:0], oy[31:0], ox[31:0]},
			{dz[31:0], dy[31:0], dx[31:0]}));
	endtask

	task automatic drain();
		ray_valid <= 1'b0;
		while (pending_isects.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Write one register; only called with the pipeline empty
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CENTER_X: sph_center[0] = longint'($signed(value));
			REG_CENTER_Y: sph_center[1] = longint'($signed(value));
			REG_CENTER_Z: sph_center[2] = longint'($signed(value));
			REG_RADIUS:   sph_radius = longint'(value[30:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_sphere(longint cx, longint cy, longint cz, longint r);
		drain();
		write_reg(REG_CENTER_X, cx[31:0]);
		write_reg(REG_CENTER_Y, cy[31:0]);
		write_reg(REG_CENTER_Z, cz[31:0]);
		write_reg(REG_RADIUS, r[31:0]);
	endtask

	function automatic longint spread(int unsigned span);
		return longint'($urandom_range(0, 2 * span)) - longint'(span);
	endfunction

	function automatic longint full32();
		return longint'($signed($urandom()));
	endfunction

	// Mostly rays aimed near the sphere, some pure noise
	task automatic test_random_rays(int count, int unsigned reach);
		longint ox, oy, oz;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_ray(full32(), full32(), full32(), full32(), full32(), full32());
			end else begin
				ox = sph_center[0] + spread(reach);
				oy = sph_center[1] + spread(reach);
				oz = sph_center[2] + spread(reach);
				send_ray(ox, oy, oz,
					sph_center[0] - ox + spread(reach / 3),
					sph_center[1] - oy + spread(reach / 3),
					sph_center[2] - oz + spread(reach / 3));
			end
		end
	endtask

	task automatic test_unit_sphere();
		send_ray(0, 0, -5 * ONE, 0, 0, ONE);           // near hit from outside
		send_ray(0, 0, 0, ONE, 0, 0);                  // origin at center
		send_ray(ONE, ONE, ONE, 0, 0, 0);              // zero direction
		send_ray(0, 0, 5 * ONE, 0, 0, ONE);            // center behind origin
		send_ray(2 * ONE, 0, -5 * ONE, 0, 0, ONE);     // passes beside
		send_ray(0, 0, -ONE, 0, 0, ONE);               // origin on surface
		send_ray(ONE, 0, -5 * ONE, 0, 0, 7);           // tangent, tiny direction
		send_ray(0, 2 * ONE, 0, ONE, 0, 0);            // projection exactly zero
		send_ray(-3 * ONE, -4 * ONE, 0, 3 * ONE, 4 * ONE, 0);
		send_ray(ONE / 2, -ONE / 3, ONE / 5, -1, 1, -1);
		send_ray(2147483647, 2147483647, 2147483647, 2147483647, 2147483647, 2147483647);
		send_ray(-2147483648, -2147483648, -2147483648, 2147483647, 2147483647, 2147483647);
		send_ray(2147483647, -2147483648, 0, -2147483648, 2147483647, 1);
		send_ray(-2147483648, 0, 0, -2147483648, -2147483648, -2147483648);
	endtask

	task automatic test_zero_radius();
		set_sphere(3 * ONE, -2 * ONE, ONE, 0);
		send_ray(3 * ONE, -2 * ONE, -4 * ONE, 0, 0, ONE);  // on the center line
		send_ray(0, 0, 0, 3 * ONE, -2 * ONE, ONE);
		send_ray(3 * ONE, -2 * ONE, ONE, ONE, ONE, 0);     // origin at center
		send_ray(0, 0, 0, ONE, 0, 0);
	endtask

	task automatic test_extreme_sphere();
		set_sphere(2147483647, -2147483648, 2147483647, 32'hFFFF_FFFF);
		send_ray(-2147483648, 2147483647, -2147483648, 2147483647, -2147483648, 2147483647);
		send_ray(0, 0, 0, ONE, -ONE, ONE);
		send_ray(2147483647, -2147483648, 2147483647, 0, 0, -1);
		test_random_rays(40, 32'h4000_0000);
		set_sphere(-2147483648, 2147483647, -2147483648, 1);
		send_ray(-2147483648, 2147483647, -2147483648 + 4 * ONE, 0, 0, -ONE);
		send_ray(0, 0, 0, -ONE, ONE, -ONE);
		test_random_rays(20, 32'h4000_0000);
	endtask

	// Writes to unused indexes must leave the sphere alone
	task automatic test_unused_index();
		set_sphere(ONE, ONE, ONE, 2 * ONE);
		for (int idx = 4; idx < (1 << IDX_W); idx++)
			write_reg(IDX_W'(idx), $urandom());
		test_random_rays(20, 8 * ONE);
	endtask

	// Stall the result side long enough to back the pipeline up into the input
	task automatic test_backpressure();
		hold_asks++;
		test_random_rays(250, 16 * ONE);
	endtask

	task automatic test_random_spheres(int phases, int per_phase);
		longint r;
		for (int p = 0; p < phases; p++) begin
			r = longint'($urandom_range(1, 1 << 24));
			set_sphere(spread(1 << 28), spread(1 << 28), spread(1 << 28),
				(p == 0) ? longint'($urandom()) : r);
			test_random_rays(per_phase, 4 * int'(sph_radius > 0 ?
				(sph_radius > (1 << 27) ? (1 << 27) : sph_radius) : ONE));
		end
	endtask

	// Result side: random stalls, one long hold on request, and the checker
	int stall_left = 0;
	int hold_left = 0;
	int hold_done = 0;
	always @(posedge clk) begin
		isect_t exp_isect;
		if (res_valid && res_ready) begin
			if (pending_isects.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				exp_isect = pending_isects.pop_front();
				if (hit !== exp_isect.hit) begin
					$error("hit: expected %0d, got %0d", exp_isect.hit, hit);
					errors++;
				end
				if (from_inside !== exp_isect.in_sph) begin
					$error("from_inside: expected %0d, got %0d", exp_isect.in_sph, from_inside);
					errors++;
				end
				if ({point_z, point_y, point_x} !== exp_isect.point) begin
					$error("point: expected %h %h %h, got %h %h %h",
						exp_isect.point[0], exp_isect.point[1], exp_isect.point[2],
						point_x, point_y, point_z);
					errors++;
				end
				if ({normal_z, normal_y, normal_x} !== exp_isect.normal) begin
					$error("normal: expected %h %h %h, got %h %h %h",
						exp_isect.normal[0], exp_isect.normal[1], exp_isect.normal[2],
						normal_x, normal_y, normal_z);
					errors++;
				end
			end
		end
		if (hold_asks != hold_done) begin
			hold_done <= hold_asks;
			hold_left <= HOLD_LEN;
			res_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 10);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	initial begin
		int waited;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unit_sphere();
		test_random_rays(80, 4 * ONE);
		test_zero_radius();
		test_unused_index();
		test_backpressure();
		test_extreme_sphere();
		test_random_spheres(4, 60);
		// last stretch: no idling on either side
		quiet = 1'b1;
		set_sphere(-ONE, 2 * ONE, 0, 3 * ONE);
		test_random_rays(60, 12 * ONE);
		ray_valid <= 1'b0;
		waited = 0;
		while (pending_isects.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_isects.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#6000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
